### hdl/nls_pkg.sv
// Shared types and constants for the natural logarithm series core.
// No dependencies; used by every module of the core.
package nls_pkg;

    localparam int INPUT_FRAC_BITS_DEF = 16;
    localparam int WORK_FRAC_BITS_DEF  = 30;
    localparam int MAX_TERMS_DEF       = 63;
    localparam int OUT_FRAC_BITS       = 24;

    localparam logic [31:0] INV_E       = 32'd1580030169;
    localparam logic [31:0] E_Q30       = 32'd2918732889;
    localparam int          INV_E_SHIFT = 32;
    localparam int          E_SHIFT     = 30;

    localparam int          TERM_COUNT_W     = 6;
    localparam logic [5:0]  TERM_COUNT_RESET = 6'd48;
    localparam logic        REG_TERM_COUNT   = 1'b0;

    typedef enum logic [1:0] {
        MUL_INV_E,
        MUL_E,
        MUL_SERIES
    } t_mul_op;

    typedef struct packed {
        logic    start;
        t_mul_op op;
    } t_mul_req;

endpackage

### hdl/nls_mul.sv
// Shared multiplier: one 32x32 product per cycle, four passes per word.
// Returns the floored, shifted product, signed for series products only. Depends on nls_pkg.
module nls_mul
    import nls_pkg::*;
#(
    parameter int WORK_FRAC_BITS = WORK_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mul_req           i_req,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_result
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [1:0]   r_step;
    logic         r_busy;
    logic         r_fin;
    logic         r_neg;
    t_mul_op      r_op;
    logic         r_done;
    logic signed [63:0] r_result;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [63:0]  a_mag;
    logic [63:0]  b_mag;
    logic signed [127:0] prod;
    logic signed [127:0] prod_sh;

    always_comb begin
        a_half = r_step[0] ? r_a[63:32] : r_a[31:0];
        b_half = r_step[1] ? r_b[63:32] : r_b[31:0];
        pp     = a_half * b_half;
        case (r_step)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        a_mag = i_a[63] ? 64'(-i_a) : 64'(i_a);
        case (i_req.op)
            MUL_INV_E: b_mag = {32'd0, INV_E};
            MUL_E:     b_mag = {32'd0, E_Q30};
            default:   b_mag = i_b[63] ? 64'(-i_b) : 64'(i_b);
        endcase
        prod = r_neg ? -$signed(r_acc) : $signed(r_acc);
        case (r_op)
            MUL_INV_E: prod_sh = prod >>> INV_E_SHIFT;
            MUL_E:     prod_sh = prod >>> E_SHIFT;
            default:   prod_sh = prod >>> WORK_FRAC_BITS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= a_mag;
                r_b    <= b_mag;
                r_neg  <= (i_req.op == MUL_SERIES) && (i_a[63] ^ i_b[63]);
                r_op   <= i_req.op;
                r_acc  <= '0;
                r_step <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc  <= r_acc + pp_sh;
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin    <= 1'b0;
                r_done   <= 1'b1;
                r_result <= prod_sh[63:0];
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### hdl/nls_div.sv
// Radix-16 restoring divider of a signed word by a small term index.
// Truncates toward zero. Depends on nls_pkg for defaults.
module nls_div
    import nls_pkg::*;
#(
    parameter int WORK_FRAC_BITS = WORK_FRAC_BITS_DEF,
    parameter int MAX_TERMS      = MAX_TERMS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [63:0]             i_z,
    input  logic [$clog2(MAX_TERMS+1)-1:0] i_k,
    output logic                           o_done,
    output logic signed [63:0]             o_q
);

    localparam int KW  = $clog2(MAX_TERMS + 1);
    localparam int DW  = ((WORK_FRAC_BITS + 4) / 4) * 4;
    localparam int NC  = DW / 4;
    localparam int CTW = $clog2(NC + 1);

    logic [DW-1:0]  r_num;
    logic [KW-1:0]  r_rem;
    logic [KW-1:0]  r_k;
    logic [CTW-1:0] r_cnt;
    logic           r_neg;
    logic           r_busy;
    logic           r_done;

    logic [DW-1:0] num_nx;
    logic [KW-1:0] rem_nx;
    logic [KW:0]   rem_ext;
    logic [63:0]   z_mag;
    logic [63:0]   q_mag;

    always_comb begin
        num_nx = r_num;
        rem_nx = r_rem;
        for (int i = 0; i < 4; i++) begin
            rem_ext = {rem_nx, num_nx[DW-1]};
            num_nx  = {num_nx[DW-2:0], 1'b0};
            if (rem_ext >= {1'b0, r_k}) begin
                rem_ext   = rem_ext - {1'b0, r_k};
                num_nx[0] = 1'b1;
            end
            rem_nx = rem_ext[KW-1:0];
        end
        z_mag = i_z[63] ? 64'(-i_z) : 64'(i_z);
        q_mag = 64'(r_num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= z_mag[DW-1:0];
                r_rem  <= '0;
                r_k    <= i_k;
                r_neg  <= i_z[63];
                r_cnt  <= CTW'(NC);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= num_nx;
                r_rem <= rem_nx;
                r_cnt <= r_cnt - CTW'(1);
                if (r_cnt == CTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_neg ? -$signed(q_mag) : $signed(q_mag);

endmodule

### hdl/natural_log_series_core.sv
// Natural logarithm core: one item at a time; each word passes through
// range reduction by the multiplier, then per series term a divider step and,
// but for the last term, a multiplier step; an invalid argument skips both.
// A new word is taken only once the previous result has gone to the output
// register; the multiplier is shared by the reduction and series steps.
// Synchronous active-low reset clears control state and sets term_count to 48.
module natural_log_series_core
    import nls_pkg::*;
#(
    parameter int INPUT_FRAC_BITS = INPUT_FRAC_BITS_DEF,
    parameter int WORK_FRAC_BITS  = WORK_FRAC_BITS_DEF,
    parameter int MAX_TERMS       = MAX_TERMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_x_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_ln_value,
    output logic               o_invalid,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int KW   = $clog2(MAX_TERMS + 1);
    localparam int CW   = (KW > TERM_COUNT_W) ? KW : TERM_COUNT_W;
    localparam int SH   = WORK_FRAC_BITS - INPUT_FRAC_BITS;
    localparam int SHL  = (SH > 0) ? SH : 0;
    localparam int SHR  = (SH < 0) ? -SH : 0;
    localparam int DO   = WORK_FRAC_BITS - OUT_FRAC_BITS;
    localparam int OSR  = (DO > 0) ? DO : 0;
    localparam int OSL  = (DO < 0) ? -DO : 0;
    localparam logic signed [63:0] ONE     = 64'sd1 <<< WORK_FRAC_BITS;
    localparam logic signed [63:0] QUARTER = 64'sd1 <<< (WORK_FRAC_BITS - 2);
    localparam logic signed [63:0] OUT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] OUT_MIN = -64'sd2147483648;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_RED_MUL,
        S_DIV,
        S_SER_MUL,
        S_FINAL,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [5:0]         r_term_count;
    logic signed [63:0] r_x;
    logic signed [63:0] r_u;
    logic signed [63:0] r_z;
    logic signed [63:0] r_sum;
    logic signed [7:0]  r_adj;
    logic               r_red_up;
    logic [KW-1:0]      r_k;
    logic [KW-1:0]      r_n;
    logic signed [31:0] r_res_ln;
    logic               r_res_inv;
    logic               r_out_valid;
    logic signed [31:0] r_out_ln;
    logic               r_out_inv;
    t_mul_req           r_mul_req;
    logic               r_div_go;

    logic               mul_done;
    logic signed [63:0] mul_res;
    logic               div_done;
    logic signed [63:0] div_q;
    logic               cfg_wr;
    logic               in_acc;
    logic signed [63:0] x_conv;
    logic [CW-1:0]      term_ext;
    logic [KW-1:0]      n_terms;
    logic signed [63:0] total;
    logic signed [63:0] total_sh;
    logic signed [31:0] ln_sat;

    nls_mul #(
        .WORK_FRAC_BITS(WORK_FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mul_req),
        .i_a     ((r_state == S_RED_MUL) ? r_x : r_z),
        .i_b     (r_u),
        .o_done  (mul_done),
        .o_result(mul_res)
    );

    nls_div #(
        .WORK_FRAC_BITS(WORK_FRAC_BITS),
        .MAX_TERMS     (MAX_TERMS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_go),
        .i_z    (r_z),
        .i_k    (r_k),
        .o_done (div_done),
        .o_q    (div_q)
    );

    always_comb begin
        cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_TERM_COUNT);
        in_acc   = i_valid && (r_state == S_IDLE);
        x_conv   = (64'(i_x_value) <<< SHL) >>> SHR;
        term_ext = CW'(r_term_count);
        n_terms  = (term_ext > CW'(MAX_TERMS)) ? KW'(MAX_TERMS) : KW'(term_ext);
        total    = r_sum + (64'(r_adj) <<< WORK_FRAC_BITS);
        total_sh = (total >>> OSR) <<< OSL;
        if (total_sh > OUT_MAX) begin
            ln_sat = 32'sh7FFFFFFF;
        end else if (total_sh < OUT_MIN) begin
            ln_sat = 32'sh80000000;
        end else begin
            ln_sat = total_sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= TERM_COUNT_RESET;
        end else if (cfg_wr) begin
            r_term_count <= pwdata[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mul_req   <= '{start: 1'b0, op: MUL_SERIES};
            r_div_go    <= 1'b0;
        end else begin
            r_mul_req.start <= 1'b0;
            r_div_go        <= 1'b0;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_x_value <= 32'sd0) begin
                            r_res_ln  <= '0;
                            r_res_inv <= 1'b1;
                            r_state   <= S_OUT;
                        end else begin
                            r_x     <= (x_conv == 64'sd0) ? 64'sd1 : x_conv;
                            r_adj   <= '0;
                            r_n     <= n_terms;
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (r_x > ONE) begin
                        r_mul_req <= '{start: 1'b1, op: MUL_INV_E};
                        r_red_up  <= 1'b1;
                        r_state   <= S_RED_MUL;
                    end else if (r_x < QUARTER) begin
                        r_mul_req <= '{start: 1'b1, op: MUL_E};
                        r_red_up  <= 1'b0;
                        r_state   <= S_RED_MUL;
                    end else begin
                        r_u   <= r_x - ONE;
                        r_z   <= r_x - ONE;
                        r_sum <= '0;
                        r_k   <= KW'(1);
                        if (r_n == '0) begin
                            r_state <= S_FINAL;
                        end else begin
                            r_div_go <= 1'b1;
                            r_state  <= S_DIV;
                        end
                    end
                end
                S_RED_MUL: begin
                    if (mul_done) begin
                        r_x     <= mul_res;
                        r_adj   <= r_red_up ? r_adj + 8'sd1 : r_adj - 8'sd1;
                        r_state <= S_RED;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_sum <= r_k[0] ? r_sum + div_q : r_sum - div_q;
                        if (r_k == r_n) begin
                            r_state <= S_FINAL;
                        end else begin
                            r_mul_req <= '{start: 1'b1, op: MUL_SERIES};
                            r_state   <= S_SER_MUL;
                        end
                    end
                end
                S_SER_MUL: begin
                    if (mul_done) begin
                        r_z      <= mul_res;
                        r_k      <= r_k + KW'(1);
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_FINAL: begin
                    r_res_ln  <= ln_sat;
                    r_res_inv <= 1'b0;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_ln    <= r_res_ln;
                        r_out_inv   <= r_res_inv;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_ln_value = r_out_ln;
    assign o_invalid  = r_out_inv;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_TERM_COUNT) ? {26'd0, r_term_count} : 32'd0;

endmodule

### hdl/nls_checker.sv
// Port-level checks for the natural logarithm series core.
// Bound to natural_log_series_core; depends on nothing else.
module nls_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_ln_value,
    input logic        o_invalid,
    input logic        pready
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("Core did not go busy after taking a word.");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_ln_value == 32'd0))
        else $error("Invalid result carries a nonzero value.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_ln_value) && $stable(o_invalid)))
        else $error("Stalled result word changed.");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("Register port not ready.");

endmodule

bind natural_log_series_core nls_checker u_nls_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_ln_value(o_ln_value),
    .o_invalid (o_invalid),
    .pready    (pready)
);

### tb/tb_natural_log_series_core.sv
// Testbench for natural_log_series_core: directed table, then random words,
// each checked against its fixed table result or a bit-exact fixed-point logarithm predictor.
// Depends on nls_pkg and natural_log_series_core.
`timescale 1ns / 1ps

module tb_natural_log_series_core;
    import nls_pkg::*;

    localparam int  WFB        = WORK_FRAC_BITS_DEF;
    localparam int  IFB        = INPUT_FRAC_BITS_DEF;
    localparam int  RANDOM_N   = 900;
    localparam longint LIMIT   = 4000000;
    localparam int  SETTLE     = 1200;

    typedef struct {
        logic signed [31:0] ln_value;
        logic               invalid;
    } t_ln_result;

    typedef struct {
        logic signed [31:0] x_value;
        bit                 fixed;
        logic signed [31:0] ln_value;
        logic               invalid;
    } t_ln_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_x_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_ln_value;
    logic               o_invalid;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    t_ln_result  ln_expected[$];
    logic [5:0]  terms_shadow = TERM_COUNT_RESET;
    int          mismatches = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          invalid_seen = 0;
    longint      cycles = 0;

    natural_log_series_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending",
                     cycles, ln_expected.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic longint mul_floor(longint a, longint b, int s);
        logic signed [127:0] p;
        p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        return longint'(p >>> s);
    endfunction

    function automatic t_ln_result predict_ln(logic signed [31:0] xin);
        t_ln_result r;
        longint one, quarter, x, u, z, acc, total;
        int adjust;
        r.ln_value = '0;
        r.invalid = 1'b0;
        one = 64'sd1 << WFB;
        quarter = 64'sd1 << (WFB - 2);
        acc = 0;
        adjust = 0;
        if (xin <= 0) begin
            r.invalid = 1'b1;
            return r;
        end
        x = longint'(xin) <<< (WFB - IFB);
        if (x == 0) x = 1;
        while (x > one) begin
            x = mul_floor(x, longint'(INV_E), INV_E_SHIFT);
            adjust++;
        end
        while (x < quarter) begin
            x = mul_floor(x, longint'(E_Q30), E_SHIFT);
            adjust--;
        end
        u = x - one;
        z = u;
        for (int k = 1; k <= int'(terms_shadow) && k <= MAX_TERMS_DEF; k++) begin
            if (k % 2 == 1) acc += z / longint'(k);
            else acc -= z / longint'(k);
            z = mul_floor(z, u, WFB);
        end
        total = (acc + longint'(adjust) * one) >>> (WFB - OUT_FRAC_BITS);
        if (total > 64'sd2147483647) total = 64'sd2147483647;
        if (total < -64'sd2147483648) total = -64'sd2147483648;
        r.ln_value = total[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_ln_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (ln_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: ln=%h invalid=%b", o_ln_value, o_invalid);
            end else begin
                want = ln_expected.pop_front();
                words_checked++;
                if (o_invalid) invalid_seen++;
                if (o_ln_value !== want.ln_value || o_invalid !== want.invalid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected ln=%h invalid=%b, got ln=%h invalid=%b",
                                 words_checked, want.ln_value, want.invalid,
                                 o_ln_value, o_invalid);
                end
            end
        end
    end

    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    task automatic send_word(logic signed [31:0] x, bit fixed, t_ln_result fixed_res);
        i_valid <= 1'b1;
        i_x_value <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        ln_expected.push_back(fixed ? fixed_res : predict_ln(x));
        words_sent++;
    endtask

    task automatic idle_sender(int n);
        i_valid <= 1'b0;
        i_x_value <= $urandom;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        idle_sender(1);
        while (ln_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_terms(logic [5:0] n);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(REG_TERM_COUNT) << 2;
        pwdata <= {2'($urandom_range(0, 3)), 24'd0, n};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        terms_shadow = n;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] random_x();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4:    return {1'b0, 31'($urandom)};
            5, 6:    return 32'sh10000 + $signed(32'($urandom_range(0, 32'h1FFFF))) - 32'sh8000;
            7:       return 32'($urandom_range(1, 32'h3FFF));
            8:       return {1'b0, 31'($urandom)} >> $urandom_range(0, 30);
            default: return -$signed({1'b0, 31'($urandom)}) >>> $urandom_range(0, 30);
        endcase
    endfunction

    t_ln_row directed[] = '{
        '{32'sh00000000, 1, 32'sh0, 1'b1},
        '{32'shFFFFFFFF, 1, 32'sh0, 1'b1},
        '{32'sh80000000, 1, 32'sh0, 1'b1},
        '{32'sh00010000, 1, 32'sh0, 1'b0},
        '{32'sh00000001, 0, 32'sh0, 1'b0},
        '{32'sh00000002, 0, 32'sh0, 1'b0},
        '{32'sh7FFFFFFF, 0, 32'sh0, 1'b0},
        '{32'sh00004000, 0, 32'sh0, 1'b0},
        '{32'sh00003FFF, 0, 32'sh0, 1'b0},
        '{32'sh00004001, 0, 32'sh0, 1'b0},
        '{32'sh00010001, 0, 32'sh0, 1'b0},
        '{32'sh0000FFFF, 0, 32'sh0, 1'b0},
        '{32'sh0002B7E1, 0, 32'sh0, 1'b0},
        '{32'sh00020000, 0, 32'sh0, 1'b0},
        '{32'sh00008000, 0, 32'sh0, 1'b0},
        '{32'sh55555555, 0, 32'sh0, 1'b0},
        '{32'sh2AAAAAAA, 0, 32'sh0, 1'b0},
        '{32'sh0F0F0F0F, 0, 32'sh0, 1'b0},
        '{32'shAAAAAAAA, 1, 32'sh0, 1'b1},
        '{32'sh00C00000, 0, 32'sh0, 1'b0}
    };

    initial begin
        t_ln_result r;
        int burst;
        logic [5:0] n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            r.ln_value = directed[i].ln_value;
            r.invalid = directed[i].invalid;
            send_word(directed[i].x_value, directed[i].fixed, r);
            if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 5));
        end
        drain();

        foreach (directed[i]) begin
            if (i == 0) write_terms(6'd0);
            if (i == 7) begin
                drain();
                write_terms(6'd1);
            end
            if (i == 14) begin
                drain();
                write_terms(6'd63);
            end
            send_word(directed[i].x_value, 0, r);
        end
        drain();

        for (int sent = 0; sent < RANDOM_N; ) begin
            if (sent % 150 == 0) begin
                drain();
                n = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(1, 12));
                write_terms(n);
            end
            burst = $urandom_range(1, 10);
            for (int b = 0; b < burst && sent < RANDOM_N; b++) begin
                send_word(random_x(), 0, r);
                sent++;
            end
            if ($urandom_range(0, 19) == 0) begin
                idle_sender(1);
                while (ln_expected.size() != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 3) != 0) begin
                idle_sender($urandom_range(1, 8));
            end
        end

        idle_sender(1);
        while (ln_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d words over term counts 0, 1, 48, 63 and random;", words_sent);
        $display("%0d checked, %0d invalid.", words_checked, invalid_seen);
        $display("Mismatches: %0d.", mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
